// File: sv/two_class_priority_queue_cancel_top_defines.svh
// assertion macros for the two-class priority queue checker
// depends on: nothing; users must have clk and rst_n in scope
`ifndef TWO_CLASS_PRIORITY_QUEUE_CANCEL_TOP_DEFINES_SVH
`define TWO_CLASS_PRIORITY_QUEUE_CANCEL_TOP_DEFINES_SVH

// property checked outside reset
`define TCPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that must also hold through reset
`define TCPQ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/tcpq_pkg.sv
// shared types and constants for the two-class priority queue
// depends on: nothing
package tcpq_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int OCC_W   = 5;
  localparam int CNT_W   = ($clog2(DEPTH + 1) > OCC_W) ? $clog2(DEPTH + 1) : OCC_W;
  localparam int KEY_W   = 30;
  localparam int PLD_W   = 16;
  localparam int CAP_W   = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(10);

  typedef enum logic [1:0] {
    CMD_INS_REG  = 2'd0,
    CMD_INS_CRIT = 2'd1,
    CMD_TAKE     = 2'd2,
    CMD_CANCEL   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_FULL        = 3'd1,
    STATUS_EMPTY_QUEUE = 3'd2,
    STATUS_NOT_FOUND   = 3'd3,
    STATUS_EMPTY_KEY   = 3'd4
  } status_t;

  typedef struct packed {
    cmd_t             command;
    logic [KEY_W-1:0] entry_key;
    logic [PLD_W-1:0] entry_payload;
  } in_t;

  typedef struct packed {
    status_t          status;
    logic [KEY_W-1:0] out_key;
    logic [PLD_W-1:0] out_payload;
    logic             out_critical;
    logic [OCC_W-1:0] occupancy;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PLD_W-1:0] payload;
    logic             critical;
  } slot_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } cell_op_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] pos;
    slot_t            new_slot;
    logic [KEY_W-1:0] match_key;
  } cell_ctl_t;

endpackage

// File: sv/two_class_priority_queue_cancel_top.sv
// top level of the two-class priority queue with keyed cancel
// depends on: tcpq_pkg, tcpq_cell
//
// Bounded queue of up to DEPTH entries kept in a row of cells, head in cell 0.
// Each command passes through the idle and execute states: in idle the transfer
// latches the command; the execute state then runs the key compare in every
// cell, finds the first match, and shifts the row by one place (right of the
// insert point for an insert, left from the removed slot for take or cancel)
// while the result is written to the output register. The block then returns
// to idle and takes no new command before the last one has executed.
// A finished result may wait in the output register while the next command is
// accepted; that command then holds in its execute cycle until the output
// register is free. Critical entries always sit ahead of regular ones. The
// capacity register (cfg_wdata, reset 10) is clipped to DEPTH; zero refuses
// every insert. Write it only while no command is in flight. There is no
// clearing pass after reset: slots beyond the entry count are never looked at.
module two_class_priority_queue_cancel_top import tcpq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t           state_r;
  in_t              cmd_r;
  logic             out_valid_r;
  out_t             out_data_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] crit_r;
  logic [CAP_W-1:0] max_entries_r;

  // cell row
  cell_ctl_t        ctl;
  slot_t            slots [DEPTH];
  logic [DEPTH-1:0] cell_match;

  // execute-cycle results
  logic             exec_fire;
  logic [CNT_W-1:0] cap;
  logic [DEPTH-1:0] match_vec;
  logic [DEPTH-1:0] first_oh;
  logic [DEPTH-1:0] sel_oh;
  logic [IDX_W-1:0] rem_pos;
  slot_t            rem_slot;
  out_t             out_nxt;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] crit_nxt;

  // execute only when the output register is free or being drained
  assign exec_fire = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  // one command at a time; the output register decouples the result side
  assign in_ready = (state_r == ST_IDLE);

  // effective capacity: register value clipped to the slot count
  assign cap = (CNT_W'(max_entries_r) < CNT_W'(DEPTH)) ? CNT_W'(max_entries_r)
                                                       : CNT_W'(DEPTH);

  // only slots below the entry count take part in the key search
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_vec[i] = cell_match[i] && (CNT_W'(i) < count_r);
    end
  end

  // first match from the head, as one-hot and as an index
  assign first_oh = match_vec & (~match_vec + DEPTH'(1));
  assign sel_oh   = (cmd_r.command == CMD_TAKE) ? DEPTH'(1) : first_oh;

  always_comb begin
    rem_pos  = '0;
    rem_slot = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (sel_oh[i]) begin
        rem_pos  = rem_pos | IDX_W'(i);
        rem_slot = rem_slot | slots[i];
      end
    end
  end

  // command decode: result, new counts and the row shift
  always_comb begin
    out_nxt   = '0;
    count_nxt = count_r;
    crit_nxt  = crit_r;
    ctl.op    = OP_HOLD;
    ctl.pos   = '0;
    ctl.new_slot.key      = cmd_r.entry_key;
    ctl.new_slot.payload  = cmd_r.entry_payload;
    ctl.new_slot.critical = (cmd_r.command == CMD_INS_CRIT);
    ctl.match_key = cmd_r.entry_key;
    out_nxt.status = STATUS_OK;

    unique case (cmd_r.command)
      CMD_INS_REG, CMD_INS_CRIT: begin
        if (count_r >= cap) begin
          out_nxt.status = STATUS_FULL;
        end else if (cmd_r.entry_key == '0) begin
          out_nxt.status = STATUS_EMPTY_KEY;
        end else begin
          ctl.op    = OP_INSERT;
          // critical goes behind the last critical entry, regular to the tail
          ctl.pos   = (cmd_r.command == CMD_INS_CRIT) ? crit_r[IDX_W-1:0]
                                                      : count_r[IDX_W-1:0];
          count_nxt = count_r + CNT_W'(1);
          if (cmd_r.command == CMD_INS_CRIT) begin
            crit_nxt = crit_r + CNT_W'(1);
          end
        end
      end
      CMD_TAKE, CMD_CANCEL: begin
        if (count_r == '0) begin
          out_nxt.status = STATUS_EMPTY_QUEUE;
        end else if (sel_oh == '0) begin
          out_nxt.status = STATUS_NOT_FOUND;
        end else begin
          ctl.op               = OP_REMOVE;
          ctl.pos              = rem_pos;
          out_nxt.out_key      = rem_slot.key;
          out_nxt.out_payload  = rem_slot.payload;
          out_nxt.out_critical = rem_slot.critical;
          count_nxt            = count_r - CNT_W'(1);
          if (rem_slot.critical && crit_r != '0) begin
            crit_nxt = crit_r - CNT_W'(1);
          end
        end
      end
      default: out_nxt.status = STATUS_OK;
    endcase

    out_nxt.occupancy = count_nxt[OCC_W-1:0];

    // the row only moves in the cycle the command commits
    if (!exec_fire) begin
      ctl.op = OP_HOLD;
    end
  end

  // the cell row: cell 0 is the head
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    slot_t left_s;
    slot_t right_s;

    if (g == 0) begin : g_head
      assign left_s = ctl.new_slot;
    end else begin : g_body
      assign left_s = slots[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_s = slots[g];
    end else begin : g_inner
      assign right_s = slots[g+1];
    end

    tcpq_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(g)),
      .ctl        (ctl),
      .left_slot  (left_s),
      .right_slot (right_s),
      .slot       (slots[g]),
      .key_match  (cell_match[g])
    );
  end

  // control state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      count_r       <= '0;
      crit_r        <= '0;
      max_entries_r <= CAP_RESET;
    end else begin
      if (cfg_we) begin
        max_entries_r <= cfg_wdata;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_EXEC;
          end
          if (out_ready) begin
            out_valid_r <= 1'b0;
          end
        end
        ST_EXEC: begin
          if (exec_fire) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            count_r     <= count_nxt;
            crit_r      <= crit_nxt;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_data;
    end
    if (exec_fire) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/tcpq_cell.sv
// one queue slot of the cell row: holds an entry, shifts toward either neighbor
// depends on: tcpq_pkg
module tcpq_cell import tcpq_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] cell_idx,
  input  cell_ctl_t        ctl,
  input  slot_t            left_slot,
  input  slot_t            right_slot,
  output slot_t            slot,
  output logic             key_match
);

  slot_t slot_r;
  slot_t slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    unique case (ctl.op)
      OP_INSERT: begin
        if (cell_idx > ctl.pos) begin
          slot_nxt = left_slot;
        end else if (cell_idx == ctl.pos) begin
          slot_nxt = ctl.new_slot;
        end
      end
      OP_REMOVE: begin
        if (cell_idx >= ctl.pos) begin
          slot_nxt = right_slot;
        end
      end
      OP_HOLD: slot_nxt = slot_r;
      default: slot_nxt = slot_r;
    endcase
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot      = slot_r;
  assign key_match = (slot_r.key == ctl.match_key);

endmodule

// File: sv/tcpq_checker.sv
// port-level checks for the two-class priority queue, bound to the top level
// depends on: tcpq_pkg, two_class_priority_queue_cancel_top_defines.svh
`include "two_class_priority_queue_cancel_top_defines.svh"

module tcpq_checker import tcpq_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // reset empties the output register
  `TCPQ_ASSERT_RST(a_rst_out, !rst_n |=> !out_valid, "output valid after reset")

  // a stalled result holds
  `TCPQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

  // one command in flight: no transfer right after a transfer
  `TCPQ_ASSERT(a_one_cmd, in_valid && in_ready |=> !in_ready, "back to back command transfer")

  // refused or failed commands return no entry
  `TCPQ_ASSERT(a_fail_zero, out_valid && out_data.status != STATUS_OK |-> out_data.out_key == '0 && out_data.out_payload == '0 && !out_data.out_critical, "entry fields set on failure")

endmodule

bind two_class_priority_queue_cancel_top tcpq_checker u_tcpq_checker (.*);

// File: tb/tcpq_response_checker.sv
// response checker for the two-class priority queue: watches both channels and the
// capacity port, predicts every response and compares it field by field
// depends on: tcpq_pkg
module tcpq_response_checker import tcpq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_t              in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_t             out_data,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               expected_left
);

  // shadow of the queue, head at index 0
  slot_t            shadow_slots [DEPTH];
  int unsigned      shadow_count;
  int unsigned      shadow_crit;
  logic [CAP_W-1:0] shadow_cap;

  out_t expected_responses [$];

  initial begin
    fail_count    = 0;
    expected_left = 0;
  end

  // pull one slot out of the shadow queue and close the gap
  function automatic slot_t pull_slot(input int unsigned pos);
    slot_t taken;
    taken = shadow_slots[pos];
    if (taken.critical && shadow_crit > 0) shadow_crit--;
    for (int unsigned i = pos; i + 1 < shadow_count; i++) shadow_slots[i] = shadow_slots[i + 1];
    shadow_count--;
    return taken;
  endfunction

  // apply one command to the shadow queue and return the response it gives
  function automatic out_t predict_response(input in_t item);
    out_t        resp;
    slot_t       taken;
    int unsigned limit;
    int unsigned pos;
    bit          hit;
    resp   = '0;
    resp.status = STATUS_OK;
    limit  = (shadow_cap < DEPTH) ? shadow_cap : DEPTH;
    hit    = 1'b0;
    pos    = 0;
    taken  = '0;
    case (item.command)
      CMD_INS_REG, CMD_INS_CRIT: begin
        if (shadow_count >= limit) begin
          resp.status = STATUS_FULL;
        end else if (item.entry_key == '0) begin
          resp.status = STATUS_EMPTY_KEY;
        end else begin
          // critical entries go behind the last critical one
          pos = (item.command == CMD_INS_CRIT) ? shadow_crit : shadow_count;
          for (int unsigned i = shadow_count; i > pos; i--) shadow_slots[i] = shadow_slots[i - 1];
          shadow_slots[pos].key      = item.entry_key;
          shadow_slots[pos].payload  = item.entry_payload;
          shadow_slots[pos].critical = (item.command == CMD_INS_CRIT);
          shadow_count++;
          if (item.command == CMD_INS_CRIT) shadow_crit++;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          resp.status = STATUS_EMPTY_QUEUE;
        end else begin
          if (item.command == CMD_TAKE) begin
            hit = 1'b1;
          end else begin
            // first match counted from the head
            for (int unsigned i = 0; i < shadow_count; i++) begin
              if (!hit && shadow_slots[i].key == item.entry_key) begin
                hit = 1'b1;
                pos = i;
              end
            end
          end
          if (hit) begin
            taken = pull_slot(pos);
            resp.out_key      = taken.key;
            resp.out_payload  = taken.payload;
            resp.out_critical = taken.critical;
          end else begin
            resp.status = STATUS_NOT_FOUND;
          end
        end
      end
    endcase
    resp.occupancy = OCC_W'(shadow_count);
    return resp;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_count = 0;
      shadow_crit  = 0;
      shadow_cap   = CAP_RESET;
      expected_responses.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_responses.size() == 0) begin
          $display("%0t: response with none expected, expected nothing, actual %0h",
                   $time, out_data);
          fail_count++;
        end else begin
          out_t want;
          want = expected_responses.pop_front();
          compare_field("status", 32'(want.status), 32'(out_data.status));
          compare_field("out_key", 32'(want.out_key), 32'(out_data.out_key));
          compare_field("out_payload", 32'(want.out_payload), 32'(out_data.out_payload));
          compare_field("out_critical", 32'(want.out_critical), 32'(out_data.out_critical));
          compare_field("occupancy", 32'(want.occupancy), 32'(out_data.occupancy));
        end
      end
      if (in_valid && in_ready) begin
        expected_responses = {expected_responses, predict_response(in_data)};
      end
      if (cfg_we) shadow_cap = cfg_wdata;
    end
    expected_left = expected_responses.size();
  end

endmodule

// File: tb/tb_two_class_priority_queue_cancel_top.sv
// testbench top for the two-class priority queue with keyed cancel: drives commands,
// capacity writes and output back-pressure, and gives the verdict
// depends on: tcpq_pkg, tcpq_response_checker, two_class_priority_queue_cancel_top
module tb_two_class_priority_queue_cancel_top;
  import tcpq_pkg::*;

  // quiet cycles before a capacity write, and after the last response
  localparam int SETTLE_CYCLES = 6;
  // receiver hold-off long enough to fill the block and stall its input
  localparam int LONG_HOLD     = 80;
  // cycles without any transfer before the run is declared hung
  localparam int WATCHDOG_MAX  = 1000;
  localparam int NUM_PHASES    = 9;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_t              in_data;
  logic             out_valid;
  logic             out_ready;
  out_t             out_data;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  int fail_count;
  int expected_left;
  int quiet_cycles;

  // handshake between the command process and the receiver for the long hold-off
  bit hold_armed;
  bit hold_done;
  // stretches with no idling on either side
  bit tx_eager;
  bit rx_eager;

  logic [KEY_W-1:0] key_pool [16];

  two_class_priority_queue_cancel_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  tcpq_response_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // keys mostly from a small pool so cancels hit and duplicates occur
  function automatic logic [KEY_W-1:0] pick_key(input int zero_pct, input int wild_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < zero_pct) return '0;
    if (roll < zero_pct + wild_pct) return KEY_W'($urandom);
    return key_pool[$urandom_range(0, 15)];
  endfunction

  // insert_pct steers the mix toward filling or draining the queue
  function automatic cmd_t pick_command(input int insert_pct);
    if ($urandom_range(0, 99) < insert_pct) begin
      return ($urandom_range(0, 99) < 40) ? CMD_INS_CRIT : CMD_INS_REG;
    end
    return ($urandom_range(0, 99) < 55) ? CMD_TAKE : CMD_CANCEL;
  endfunction

  // one command transfer; called at a falling edge, returns at a falling edge with
  // valid still up so that a following command can go out back to back
  task automatic send_command(input cmd_t cmd, input logic [KEY_W-1:0] key,
                              input logic [PLD_W-1:0] payload);
    int gap;
    gap = tx_eager ? 0 : idle_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.command       = cmd;
    in_data.entry_key     = key;
    in_data.entry_payload = payload;
    in_valid              = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // sender pauses until every expected response has come back
  task automatic drain_responses();
    in_valid = 1'b0;
    while (expected_left != 0) @(negedge clk);
  endtask

  // capacity writes only with nothing in flight
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    drain_responses();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // receiver: random back-pressure, eager stretches, and one long hold-off
  initial begin
    int stall;
    int ticks;
    out_ready = 1'b0;
    rx_eager  = 1'b0;
    hold_done = 1'b0;
    stall     = 0;
    ticks     = 0;
    forever begin
      @(negedge clk);
      ticks++;
      if (ticks % 200 == 0) rx_eager = ($urandom_range(0, 3) == 0);
      if (hold_armed && !hold_done) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
        out_ready = 1'b1;
      end else if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else begin
        out_ready = 1'b1;
        if (!rx_eager) stall = idle_len();
      end
    end
  end

  // watchdog: any transfer resets the count of quiet cycles
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase_cap   [NUM_PHASES];
    int phase_items [NUM_PHASES];
    int insert_pct;
    cmd_t cmd;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    hold_armed = 1'b0;
    tx_eager   = 1'b0;
    // capacity 31 clips to the depth, 0 refuses every insert
    phase_cap   = '{16, 31, 0, 1, 2, 5, 12, 16, 10};
    phase_items = '{160, 160, 30, 120, 120, 150, 160, 180, 170};
    key_pool[0] = KEY_W'(1);
    key_pool[1] = '1;
    key_pool[2] = KEY_W'(999999999);
    for (int i = 3; i < 16; i++) key_pool[i] = KEY_W'($urandom_range(1, 999999999));
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty queue, empty key, class ordering, cancel at middle and tail
    send_command(CMD_TAKE, '0, '0);
    send_command(CMD_CANCEL, KEY_W'(7), '0);
    send_command(CMD_INS_REG, '0, 16'h1234);
    send_command(CMD_INS_REG, '1, '1);
    send_command(CMD_INS_CRIT, KEY_W'(1), '0);
    send_command(CMD_INS_CRIT, KEY_W'(999999999), 16'h5A5A);
    send_command(CMD_INS_REG, KEY_W'(30'h15555555), 16'hAAAA);
    send_command(CMD_CANCEL, KEY_W'(12345), '0);
    send_command(CMD_CANCEL, '0, '0);
    send_command(CMD_CANCEL, KEY_W'(999999999), '0);
    send_command(CMD_CANCEL, KEY_W'(30'h15555555), '0);
    send_command(CMD_TAKE, '0, '0);
    send_command(CMD_TAKE, '0, '0);
    send_command(CMD_TAKE, '0, '0);

    // capacity of one: second insert is full, full is reported ahead of an empty key
    write_capacity(CAP_W'(1));
    send_command(CMD_INS_REG, KEY_W'(77), 16'h00FF);
    send_command(CMD_INS_REG, KEY_W'(78), 16'hFF00);
    send_command(CMD_INS_REG, '0, '0);
    send_command(CMD_INS_CRIT, KEY_W'(79), '0);
    send_command(CMD_TAKE, '0, '0);

    // capacity of zero refuses every insert
    write_capacity('0);
    send_command(CMD_INS_CRIT, KEY_W'(5), 16'h0005);

    // random phases, with fill-heavy, drain-heavy and balanced runs picked at random
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(CAP_W'(phase_cap[p]));
      tx_eager = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < phase_items[p]; n++) begin
        // long receiver hold-off while commands keep coming
        if (p == 0 && n == 20) hold_armed = 1'b1;
        if (n == phase_items[p] / 2) drain_responses();
        if (n % 16 == 0) begin
          case ($urandom_range(0, 2))
            0:       insert_pct = 75;
            1:       insert_pct = 25;
            default: insert_pct = 50;
          endcase
        end
        cmd = pick_command(insert_pct);
        if (cmd == CMD_CANCEL) begin
          send_command(cmd, pick_key(8, 20), PLD_W'($urandom));
        end else begin
          send_command(cmd, pick_key(4, 10), PLD_W'($urandom));
        end
      end
    end

    drain_responses();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
